// ===== hw/rtl/ctk_pkg.sv =====
// Shared constants, codes and types of the cosine top-K vector search block.
`default_nettype none

package ctk_pkg;

  localparam int ENTRIES    = 256;
  localparam int DIMS       = 64;
  localparam int TOP_K      = 16;
  localparam int VALUE_BITS = 16;

  localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DIM_W   = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int K_W     = $clog2(TOP_K + 1);
  localparam int VEC_AW  = ENTRY_W + DIM_W;

  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MAXRES_W   = 5;
  localparam int DIMSCFG_W  = 7;

  // Arithmetic widths of the score datapath.
  localparam int MAG_W    = 2 * VALUE_BITS - 1 + DIM_W;
  localparam int DOT_W    = 2 * VALUE_BITS + DIM_W;
  localparam int SQ_IN_W  = MAG_W + 8;
  localparam int SQ_IN_WE = SQ_IN_W + (SQ_IN_W % 2);
  localparam int SQ_W     = SQ_IN_WE / 2;
  localparam int D_W      = 2 * SQ_W;
  localparam int SHIFT    = VALUE_BITS - 1 + 8;
  localparam int DIV_A    = DOT_W + SHIFT;
  localparam int DIV_B    = D_W + VALUE_BITS;
  localparam int DIV_W    = ((DIV_A > DIV_B) ? DIV_A : DIV_B) + 1;
  localparam int QCNT_W   = $clog2(VALUE_BITS + 1);

  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS      = 2'd3;

  localparam logic [MAXRES_W-1:0]  MAXRES_RESET = 5'd10;
  localparam logic [DIMSCFG_W-1:0] DIMS_RESET   = 7'd64;

  localparam logic signed [VALUE_BITS-1:0] SCORE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] SCORE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef struct packed {
    logic                         valid;
    logic signed [VALUE_BITS-1:0] score;
    logic [ENTRY_W-1:0]           entry;
  } cell_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic                         done;
    logic signed [VALUE_BITS-1:0] score;
  } score_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ctk_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ctk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ctk_cell.sv =====
// One cell of the sorted top-K hit list.
`default_nettype none

module ctk_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctk_pkg::cell_ctl_t ctl,
  input  wire ctk_pkg::cell_t    cand,
  input  wire logic              limit_ok,
  input  wire ctk_pkg::cell_t    left,
  input  wire logic              left_ins,
  input  wire ctk_pkg::cell_t    right,
  output ctk_pkg::cell_t         cur,
  output logic                   ins
);

  ctk_pkg::cell_t cur_r;
  ctk_pkg::cell_t cur_nxt;

  // A held score that is equal to the candidate stays ahead: it has the lower entry.
  assign ins = limit_ok && !(cur_r.valid && ($signed(cur_r.score) >= $signed(cand.score)));
  assign cur = cur_r;

  always_comb begin
    cur_nxt = cur_r;
    priority if (ctl.clear) begin
      cur_nxt.valid = 1'b0;
    end else if (ctl.shift) begin
      cur_nxt = right;
    end else if (ctl.insert && ins) begin
      if (left_ins) begin
        cur_nxt = left;
      end else begin
        cur_nxt       = cand;
        cur_nxt.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ctk_score.sv =====
// Cosine score unit: two bit-serial square roots, one multiply, a restoring divide.
`default_nettype none

module ctk_score (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [ctk_pkg::DOT_W-1:0]  dot,
  input  wire logic [ctk_pkg::MAG_W-1:0]         mq,
  input  wire logic [ctk_pkg::MAG_W-1:0]         mv,
  output ctk_pkg::score_res_t                    res
);

  typedef enum logic [5:0] {
    E_IDLE = 6'b000001,
    E_SQRT = 6'b000010,
    E_MUL  = 6'b000100,
    E_PREP = 6'b001000,
    E_DIV  = 6'b010000,
    E_FIN  = 6'b100000
  } eng_state_t;

  eng_state_t st_r, st_nxt;

  logic [ctk_pkg::SQ_IN_WE-1:0]   n1_r, n2_r, r1_r, r2_r, bit_r;
  logic [ctk_pkg::SQ_IN_WE-1:0]   n1_nxt, n2_nxt, r1_nxt, r2_nxt, t1, t2;
  logic [ctk_pkg::D_W-1:0]        d_r;
  logic [ctk_pkg::DIV_W-1:0]      rem_r, ds_r;
  logic [ctk_pkg::VALUE_BITS-1:0] q_r;
  logic [ctk_pkg::QCNT_W-1:0]     b_r;
  logic [ctk_pkg::DOT_W-1:0]      mag_r;
  logic                           neg_r, zero_r, ovf_r, done_r, ge;
  logic signed [ctk_pkg::VALUE_BITS-1:0] score_r, score_nxt;

  assign res.done  = done_r;
  assign res.score = score_r;

  // One step of the digit-by-digit square root for each magnitude.
  always_comb begin
    t1     = r1_r + bit_r;
    t2     = r2_r + bit_r;
    n1_nxt = n1_r;
    n2_nxt = n2_r;
    r1_nxt = r1_r >> 1;
    r2_nxt = r2_r >> 1;
    if (n1_r >= t1) begin
      n1_nxt = n1_r - t1;
      r1_nxt = (r1_r >> 1) + bit_r;
    end
    if (n2_r >= t2) begin
      n2_nxt = n2_r - t2;
      r2_nxt = (r2_r >> 1) + bit_r;
    end
  end

  assign ge = rem_r >= ds_r;

  always_comb begin
    if (zero_r) begin
      score_nxt = '0;
    end else if (neg_r) begin
      score_nxt = (ovf_r || q_r[ctk_pkg::VALUE_BITS-1]) ? ctk_pkg::SCORE_MIN : -$signed(q_r);
    end else begin
      score_nxt = (ovf_r || (q_r >= ctk_pkg::SCORE_MAX)) ? ctk_pkg::SCORE_MAX : $signed(q_r);
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      E_IDLE: if (start) st_nxt = ((mq == '0) || (mv == '0)) ? E_FIN : E_SQRT;
      E_SQRT: if (bit_r[0]) st_nxt = E_MUL;
      E_MUL:  st_nxt = E_PREP;
      E_PREP: st_nxt = E_DIV;
      E_DIV:  if (b_r == '0) st_nxt = E_FIN;
      E_FIN:  st_nxt = E_IDLE;
      default: st_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= E_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == E_FIN);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      E_IDLE: begin
        if (start) begin
          neg_r  <= dot < 0;
          mag_r  <= (dot < 0) ? ctk_pkg::DOT_W'(-dot) : ctk_pkg::DOT_W'(dot);
          zero_r <= (mq == '0) || (mv == '0);
          n1_r   <= ctk_pkg::SQ_IN_WE'(mq) << 8;
          n2_r   <= ctk_pkg::SQ_IN_WE'(mv) << 8;
          r1_r   <= '0;
          r2_r   <= '0;
          bit_r  <= ctk_pkg::SQ_IN_WE'(1) << (ctk_pkg::SQ_IN_WE - 2);
        end
      end
      E_SQRT: begin
        n1_r  <= n1_nxt;
        n2_r  <= n2_nxt;
        r1_r  <= r1_nxt;
        r2_r  <= r2_nxt;
        bit_r <= bit_r >> 2;
      end
      E_MUL: begin
        d_r <= r1_r[ctk_pkg::SQ_W-1:0] * r2_r[ctk_pkg::SQ_W-1:0];
      end
      E_PREP: begin
        rem_r <= (ctk_pkg::DIV_W'(mag_r) << ctk_pkg::SHIFT) + ctk_pkg::DIV_W'(d_r >> 1);
        ds_r  <= ctk_pkg::DIV_W'(d_r) << ctk_pkg::VALUE_BITS;
        b_r   <= ctk_pkg::QCNT_W'(ctk_pkg::VALUE_BITS);
        q_r   <= '0;
        ovf_r <= 1'b0;
      end
      E_DIV: begin
        // The first step only checks that the quotient fits; later steps make one bit each.
        if (b_r == ctk_pkg::QCNT_W'(ctk_pkg::VALUE_BITS)) begin
          ovf_r <= ge;
        end else begin
          if (ge) begin
            rem_r <= rem_r - ds_r;
          end
          q_r <= {q_r[ctk_pkg::VALUE_BITS-2:0], ge};
        end
        ds_r <= ds_r >> 1;
        b_r  <= b_r - 1'b1;
      end
      E_FIN: begin
        score_r <= score_nxt;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cosine_top_k_vector_search.sv =====
// Store, delete and plain query beats are taken while no search runs; stores then stream one per cycle.
// A closing query scans every entry: an invalid entry is stepped over, and a valid entry passes
// through the element read pipeline and then the root, multiply and divide unit (which is
// skipped when a magnitude is zero). Hits then leave one per cycle while out_stall is low,
// from the head of the sorted cell row; input stalls meanwhile.
// Reset is synchronous: it clears the valid marks, the hit list and the control state
// and loads the register defaults; vector and query memories are not cleared.
`default_nettype none

module cosine_top_k_vector_search (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [ctk_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [ctk_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [ctk_pkg::KIND_W-1:0]             in_kind,
  input  wire logic [ctk_pkg::ENTRY_W-1:0]            in_entry_index,
  input  wire logic [ctk_pkg::DIM_W-1:0]              in_dim_index,
  input  wire logic signed [ctk_pkg::VALUE_BITS-1:0]  in_element_value,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        out_success,
  output logic                                        out_hit,
  output logic [ctk_pkg::ENTRY_W-1:0]                 out_hit_entry,
  output logic signed [ctk_pkg::VALUE_BITS-1:0]       out_score,
  output logic                                        out_last
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ENTRY  = 7'b0000010,
    ST_ACCUM  = 7'b0000100,
    ST_SCORE  = 7'b0001000,
    ST_INSERT = 7'b0010000,
    ST_EMIT   = 7'b0100000,
    ST_FAIL   = 7'b1000000
  } state_t;

  localparam int VB = ctk_pkg::VALUE_BITS;

  state_t state_r, state_nxt;

  logic                                enabled_r;
  logic signed [VB-1:0]                thr_r;
  logic [ctk_pkg::MAXRES_W-1:0]        maxres_r;
  logic [ctk_pkg::DIMSCFG_W-1:0]       dims_r;
  logic [ctk_pkg::ENTRIES-1:0]         valid_r;

  logic [ctk_pkg::ENTRY_W-1:0]         e_r;
  logic [ctk_pkg::DIM_W-1:0]           i_r;
  logic                                issuing_r, p1_r, p2_r;
  logic signed [2*VB-1:0]              p_dot_r;
  logic [2*VB-2:0]                     p_qq_r, p_vv_r;
  logic signed [ctk_pkg::DOT_W-1:0]    dot_r;
  logic [ctk_pkg::MAG_W-1:0]           mq_r, mv_r;

  logic                                out_valid_r, out_success_r, out_hit_r, out_last_r;
  logic [ctk_pkg::ENTRY_W-1:0]         out_entry_r;
  logic signed [VB-1:0]                out_score_r;

  logic                                acc, dim_ok, entry_ok, finish, last_entry, out_free;
  logic                                vec_we, q_we, eng_start;
  logic [ctk_pkg::DIM_W-1:0]           nd_m1;
  logic [ctk_pkg::K_W-1:0]             k_lim;
  logic [VB-1:0]                       q_rd, v_rd;
  logic signed [2*VB-1:0]              prod_qv, prod_qq, prod_vv;
  ctk_pkg::score_res_t                 eng_res;
  ctk_pkg::cell_ctl_t                  ctl;
  ctk_pkg::cell_t                      cand;
  ctk_pkg::cell_t                      cell_q   [0:ctk_pkg::TOP_K];
  ctk_pkg::cell_t                      left_c   [0:ctk_pkg::TOP_K-1];
  logic                                left_ins [0:ctk_pkg::TOP_K-1];
  logic                                ins_q    [0:ctk_pkg::TOP_K-1];

  assign in_stall = (state_r != ST_IDLE);
  assign acc      = in_valid && !in_stall;
  assign dim_ok   = int'(in_dim_index) < ctk_pkg::DIMS;
  assign entry_ok = int'(in_entry_index) < ctk_pkg::ENTRIES;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (dims_r == '0) begin
      nd_m1 = '0;
    end else if (int'(dims_r) > ctk_pkg::DIMS) begin
      nd_m1 = ctk_pkg::DIM_W'(ctk_pkg::DIMS - 1);
    end else begin
      nd_m1 = ctk_pkg::DIM_W'(dims_r - 1'b1);
    end
    k_lim = (int'(maxres_r) > ctk_pkg::TOP_K) ? ctk_pkg::K_W'(ctk_pkg::TOP_K)
                                              : ctk_pkg::K_W'(maxres_r);
  end

  assign finish     = acc && (in_kind == ctk_pkg::KIND_QUERY) && dim_ok && (in_dim_index == nd_m1);
  assign last_entry = (e_r == ctk_pkg::ENTRY_W'(ctk_pkg::ENTRIES - 1));
  assign vec_we     = acc && (in_kind == ctk_pkg::KIND_STORE) && enabled_r && entry_ok && dim_ok;
  assign q_we       = acc && (in_kind == ctk_pkg::KIND_QUERY) && dim_ok;
  assign eng_start  = (state_r == ST_ACCUM) && !issuing_r && !p1_r && !p2_r;

  ctk_ram #(.WIDTH(VB), .DEPTH(2 ** ctk_pkg::VEC_AW)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr ({in_entry_index, in_dim_index}),
    .wdata (in_element_value),
    .raddr ({e_r, i_r}),
    .rdata (v_rd)
  );

  ctk_ram #(.WIDTH(VB), .DEPTH(2 ** ctk_pkg::DIM_W)) u_query_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (in_dim_index),
    .wdata (in_element_value),
    .raddr (i_r),
    .rdata (q_rd)
  );

  ctk_score u_score (
    .clk   (clk),
    .rst_n (rst_n),
    .start (eng_start),
    .dot   (dot_r),
    .mq    (mq_r),
    .mv    (mv_r),
    .res   (eng_res)
  );

  // Sorted hit list: a row of cells, best at cell 0, shifting right on insert, left on emit.
  always_comb begin
    ctl.clear  = (state_r == ST_IDLE) && finish && enabled_r;
    ctl.insert = (state_r == ST_INSERT) && ($signed(eng_res.score) >= thr_r);
    ctl.shift  = (state_r == ST_EMIT) && out_free;
    cand.valid = 1'b1;
    cand.score = eng_res.score;
    cand.entry = e_r;
  end

  assign cell_q[ctk_pkg::TOP_K] = '0;

  for (genvar j = 0; j < ctk_pkg::TOP_K; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign left_c[j]   = '0;
      assign left_ins[j] = 1'b0;
    end else begin : g_body
      assign left_c[j]   = cell_q[j-1];
      assign left_ins[j] = ins_q[j-1];
    end
    ctk_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .cand     (cand),
      .limit_ok (ctk_pkg::K_W'(j) < k_lim),
      .left     (left_c[j]),
      .left_ins (left_ins[j]),
      .right    (cell_q[j+1]),
      .cur      (cell_q[j]),
      .ins      (ins_q[j])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (finish) state_nxt = enabled_r ? ST_ENTRY : ST_FAIL;
      ST_ENTRY: begin
        if (valid_r[e_r]) begin
          state_nxt = ST_ACCUM;
        end else if (last_entry) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_ACCUM:  if (eng_start) state_nxt = ST_SCORE;
      ST_SCORE:  if (eng_res.done) state_nxt = ST_INSERT;
      ST_INSERT: state_nxt = last_entry ? ST_EMIT : ST_ENTRY;
      ST_EMIT:   if (out_free && !cell_q[1].valid) state_nxt = ST_IDLE;
      ST_FAIL:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      enabled_r <= 1'b0;
      thr_r     <= '0;
      maxres_r  <= ctk_pkg::MAXRES_RESET;
      dims_r    <= ctk_pkg::DIMS_RESET;
      valid_r   <= '0;
      issuing_r <= 1'b0;
      p1_r      <= 1'b0;
      p2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ctk_pkg::CFG_ENABLED:   enabled_r <= cfg_wdata[0];
          ctk_pkg::CFG_THRESHOLD: thr_r     <= $signed(cfg_wdata[VB-1:0]);
          ctk_pkg::CFG_MAX_RES:   maxres_r  <= cfg_wdata[ctk_pkg::MAXRES_W-1:0];
          ctk_pkg::CFG_DIMS:      dims_r    <= cfg_wdata[ctk_pkg::DIMSCFG_W-1:0];
          default: begin
          end
        endcase
      end
      if (acc && enabled_r && entry_ok) begin
        if (in_kind == ctk_pkg::KIND_STORE && dim_ok) begin
          valid_r[in_entry_index] <= 1'b1;
        end else if (in_kind == ctk_pkg::KIND_DELETE) begin
          valid_r[in_entry_index] <= 1'b0;
        end
      end
      if (state_r == ST_ENTRY && valid_r[e_r]) begin
        issuing_r <= 1'b1;
      end else if (state_r == ST_ACCUM && issuing_r && i_r == nd_m1) begin
        issuing_r <= 1'b0;
      end
      p1_r <= issuing_r;
      p2_r <= p1_r;
      if (out_free) begin
        out_valid_r <= (state_r == ST_EMIT) || (state_r == ST_FAIL);
      end
    end
  end

  assign prod_qv = $signed(q_rd) * $signed(v_rd);
  assign prod_qq = $signed(q_rd) * $signed(q_rd);
  assign prod_vv = $signed(v_rd) * $signed(v_rd);

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      e_r <= '0;
    end else if ((state_r == ST_ENTRY && !valid_r[e_r] && !last_entry) ||
                 (state_r == ST_INSERT && !last_entry)) begin
      e_r <= e_r + 1'b1;
    end
    if (state_r == ST_ENTRY) begin
      i_r   <= '0;
      dot_r <= '0;
      mq_r  <= '0;
      mv_r  <= '0;
    end else begin
      if (issuing_r) begin
        i_r <= i_r + 1'b1;
      end
      if (p2_r) begin
        dot_r <= dot_r + ctk_pkg::DOT_W'(p_dot_r);
        mq_r  <= mq_r + ctk_pkg::MAG_W'(p_qq_r);
        mv_r  <= mv_r + ctk_pkg::MAG_W'(p_vv_r);
      end
    end
    p_dot_r <= prod_qv;
    p_qq_r  <= prod_qq[2*VB-2:0];
    p_vv_r  <= prod_vv[2*VB-2:0];
    if (out_free) begin
      if (state_r == ST_FAIL) begin
        out_success_r <= 1'b0;
        out_hit_r     <= 1'b0;
        out_entry_r   <= '0;
        out_score_r   <= '0;
        out_last_r    <= 1'b1;
      end else begin
        out_success_r <= 1'b1;
        out_hit_r     <= cell_q[0].valid;
        out_entry_r   <= cell_q[0].valid ? cell_q[0].entry : '0;
        out_score_r   <= cell_q[0].valid ? cell_q[0].score : '0;
        out_last_r    <= !cell_q[1].valid;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_success   = out_success_r;
  assign out_hit       = out_hit_r;
  assign out_hit_entry = out_entry_r;
  assign out_score     = out_score_r;
  assign out_last      = out_last_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("scan controller state is not one-hot");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (state_r == ST_IDLE))
    else $error("input beat taken while a search runs");

  a_list_packed: assert property (@(posedge clk) disable iff (!rst_n)
    cell_q[1].valid |-> cell_q[0].valid)
    else $error("hit list has a hole at its head");

  a_list_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    cell_q[1].valid |-> ($signed(cell_q[0].score) >= $signed(cell_q[1].score)))
    else $error("hit list out of order");

endmodule

`default_nettype wire
